/* rtl/ldpc_bf_pkg.sv */
// shared types, constants and code description for the (16,8) bit-flip decoder
// no dependencies; imported by every module of the decoder

package ldpc_bf_pkg;

    localparam int CODE_LEN  = 16;
    localparam int INFO_LEN  = 8;
    localparam int CHECK_CNT = 8;
    localparam int ITER_W    = 6;
    localparam int VOTE_W    = 2;
    localparam int IDX_W     = 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // register map
    localparam logic [APB_AW-1:0]  ADDR_MAX_ITER  = 3'd0;
    localparam logic [ITER_W-1:0]  MAX_ITER_RESET = 6'd10;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // outcome of one syndrome, vote and flip pass
    typedef struct packed {
        logic                syn_ok;     // all checks satisfied
        logic                vote_found; // some bit holds a vote
        logic [CODE_LEN-1:0] flip_mask;  // one-hot bit to flip
    } pass_res_t;

    // code bits covered by check r: info r, r+1, r+2 (mod 8) and parity 8+r
    function automatic logic [CODE_LEN-1:0] check_mask(input logic [2:0] r);
        logic [CODE_LEN-1:0] m;
        logic [2:0]          b;
        logic [2:0]          c;
        b = r + 3'd1;
        c = r + 3'd2;
        m = '0;
        m[r]         = 1'b1;
        m[b]         = 1'b1;
        m[c]         = 1'b1;
        m[{1'b1, r}] = 1'b1;
        return m;
    endfunction

endpackage

/* rtl/ldpc_16_8_bit_flip_decoder.sv */
// (16,8) ldpc hard-decision bit-flip decoder: apb register, sequencer, output register
// accept loads the word, then k flip passes follow, k = flips done (0..max_iterations, at most 63)
// one item in the loop at a time, one shared pass unit evaluated once per cycle
// reset: synchronous active-low aresetn clears control state, max_iterations returns to 10
// depends on ldpc_bf_pkg and ldpc_bf_pass

module ldpc_16_8_bit_flip_decoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ldpc_bf_pkg::CODE_LEN-1:0]     s_tdata,   // [15:0] hard_bits
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ldpc_bf_pkg::INFO_LEN-1:0]     m_tdata,   // [7:0] info_bits
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ldpc_bf_pkg::APB_AW-1:0]       paddr,
    input  logic [ldpc_bf_pkg::APB_DW-1:0]       pwdata,
    output logic [ldpc_bf_pkg::APB_DW-1:0]       prdata,
    output logic                                 pready
);
    import ldpc_bf_pkg::*;

    state_t               state_reg, state_next;
    logic [CODE_LEN-1:0]  word_reg, word_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic [ITER_W-1:0]    max_iter_reg, max_iter_next;
    logic                 out_valid_reg, out_valid_next;
    logic [INFO_LEN-1:0]  out_data_reg, out_data_next;
    pass_res_t            pres;
    logic                 in_acc;
    logic                 out_free;
    logic                 finish;
    logic                 cfg_wr;

    // shared pass unit
    ldpc_bf_pass u_pass (
        .word (word_reg),
        .res  (pres)
    );

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign finish   = (iter_reg == max_iter_reg) || pres.syn_ok || !pres.vote_found;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == ADDR_MAX_ITER[APB_AW-1:2]);

    always_comb begin
        max_iter_next = max_iter_reg;
        if (cfg_wr) begin
            max_iter_next = pwdata[ITER_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1:2] == ADDR_MAX_ITER[APB_AW-1:2]) begin
            prdata = APB_DW'(max_iter_reg);
        end
    end

    // sequencer: load, then one flip pass per cycle until done
    always_comb begin
        state_next     = state_reg;
        word_next      = word_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    word_next  = s_tdata;
                    iter_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_data_next  = word_reg[INFO_LEN-1:0];
                        state_next     = ST_IDLE;
                    end
                end else begin
                    word_next = word_reg ^ pres.flip_mask;
                    iter_next = iter_reg + ITER_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            max_iter_reg  <= MAX_ITER_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            max_iter_reg  <= max_iter_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        word_reg     <= word_next;
        iter_reg     <= iter_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // an accepted item always starts the iteration loop
    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (state_reg == ST_RUN))
        else $error("accepted item did not start the loop");

    // a flip pass changes exactly one code bit
    a_one_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && !finish) |=> ($countones(word_reg ^ $past(word_reg)) == 1))
        else $error("flip pass changed other than one bit");

    // a satisfied word with a free output register is delivered next cycle
    a_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && pres.syn_ok && out_free)
        |=> (m_tvalid && state_reg == ST_IDLE && m_tdata == $past(word_reg[INFO_LEN-1:0])))
        else $error("satisfied word not delivered");
`endif

endmodule

/* rtl/ldpc_bf_pass.sv */
// shared pass unit: syndrome, per-bit vote count and lowest-index maximum search
// depends on ldpc_bf_pkg

module ldpc_bf_pass (
    input  logic [ldpc_bf_pkg::CODE_LEN-1:0] word,
    output ldpc_bf_pkg::pass_res_t           res
);
    import ldpc_bf_pkg::*;

    logic [CODE_LEN-1:0]  cmask [CHECK_CNT];
    logic [CHECK_CNT-1:0] fail;
    logic [VOTE_W-1:0]    votes [CODE_LEN];
    logic [VOTE_W-1:0]    v1 [8];
    logic [IDX_W-1:0]     i1 [8];
    logic [VOTE_W-1:0]    v2 [4];
    logic [IDX_W-1:0]     i2 [4];
    logic [VOTE_W-1:0]    v3 [2];
    logic [IDX_W-1:0]     i3 [2];
    logic [VOTE_W-1:0]    v4;
    logic [IDX_W-1:0]     i4;

    // syndrome: one parity per check
    always_comb begin
        for (int r = 0; r < CHECK_CNT; r++) begin
            cmask[r] = check_mask(3'(r));
            fail[r]  = ^(word & cmask[r]);
        end
    end

    // votes: one per failing check that covers the bit
    always_comb begin
        for (int i = 0; i < CODE_LEN; i++) begin
            votes[i] = '0;
            for (int r = 0; r < CHECK_CNT; r++) begin
                if (fail[r] && cmask[r][i]) begin
                    votes[i] = votes[i] + VOTE_W'(1);
                end
            end
        end
    end

    // maximum search tree, lower index wins on a tie
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (votes[2*k+1] > votes[2*k]) begin
                v1[k] = votes[2*k+1];
                i1[k] = IDX_W'(2*k+1);
            end else begin
                v1[k] = votes[2*k];
                i1[k] = IDX_W'(2*k);
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (v1[2*k+1] > v1[2*k]) begin
                v2[k] = v1[2*k+1];
                i2[k] = i1[2*k+1];
            end else begin
                v2[k] = v1[2*k];
                i2[k] = i1[2*k];
            end
        end
        for (int k = 0; k < 2; k++) begin
            if (v2[2*k+1] > v2[2*k]) begin
                v3[k] = v2[2*k+1];
                i3[k] = i2[2*k+1];
            end else begin
                v3[k] = v2[2*k];
                i3[k] = i2[2*k];
            end
        end
        if (v3[1] > v3[0]) begin
            v4 = v3[1];
            i4 = i3[1];
        end else begin
            v4 = v3[0];
            i4 = i3[0];
        end
    end

    // pass outcome
    always_comb begin
        res.syn_ok          = (fail == '0);
        res.vote_found      = (v4 != '0);
        res.flip_mask       = '0;
        res.flip_mask[i4]   = 1'b1;
    end

endmodule
